// ----- rtl/rsse_pkg.sv -----
// Shared types and codes for the rank-sorted set engine.
package rsse_pkg;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_READ   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2,
        ST_RANGE  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] rank;
        logic [7:0] element;
    } entry_t;

    // Broadcast from the control to every cell.
    typedef struct packed {
        logic       ins_en;
        logic       rem_en;
        logic [7:0] rank;
        entry_t     new_entry;
    } cell_cmd_t;

    // What each cell reports about itself against the broadcast rank.
    typedef struct packed {
        logic after;   // new entry belongs at or before this cell
        logic ge;      // occupied and rank at least the broadcast rank
        logic eq;      // occupied and rank equal to the broadcast rank
        logic rd_hit;  // occupied and addressed by the read position
    } cell_flags_t;

endpackage

// ----- rtl/rsse_cell.sv -----
// One storage cell of the sorted chain: holds an entry and shifts with its neighbors.
module rsse_cell #(
    parameter int IDX = 0,
    parameter int CW  = 9
) (
    input  logic                clk,
    input  rsse_pkg::cell_cmd_t cmd,
    input  logic [CW-1:0]       count,
    input  logic [7:0]          position,
    input  rsse_pkg::entry_t    left_entry,
    input  logic                left_after,
    input  rsse_pkg::entry_t    right_entry,
    output rsse_pkg::entry_t    entry,
    output rsse_pkg::cell_flags_t flags
);
    import rsse_pkg::*;

    localparam bit ADDRESSABLE = (IDX < 256);

    entry_t entry_reg;
    entry_t entry_next;
    logic   occupied;

    assign occupied = count > CW'(IDX);
    assign entry    = entry_reg;

    always_comb
    begin
        // Cells past the last entry count as "after" so that the free slot
        // right behind the tail takes a new largest entry.
        flags.after  = !occupied || (entry_reg.rank > cmd.rank);
        flags.ge     = occupied && (entry_reg.rank >= cmd.rank);
        flags.eq     = occupied && (entry_reg.rank == cmd.rank);
        flags.rd_hit = ADDRESSABLE && occupied && (position == 8'(IDX));
    end

    always_comb
    begin
        entry_next = entry_reg;
        priority if (cmd.ins_en && flags.after)
        begin
            entry_next = left_after ? left_entry : cmd.new_entry;
        end
        else if (cmd.rem_en && flags.ge)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ----- rtl/rsse_chain.sv -----
// Row of cells with the match and read-out reductions across them.
module rsse_chain #(
    parameter int CAPACITY = 256,
    parameter int CW       = 9
) (
    input  logic                clk,
    input  rsse_pkg::cell_cmd_t cmd,
    input  logic [CW-1:0]       count,
    input  logic [7:0]          position,
    output logic                found,
    output logic                rd_found,
    output rsse_pkg::entry_t    rd_entry
);
    import rsse_pkg::*;

    entry_t      entries [CAPACITY];
    cell_flags_t flags   [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t left_entry;
        entry_t right_entry;
        logic   left_after;

        if (i == 0)
        begin : g_head
            assign left_entry = entries[0];
            assign left_after = 1'b0;
        end
        else
        begin : g_body
            assign left_entry = entries[i-1];
            assign left_after = flags[i-1].after;
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_entry = entries[i];
        end
        else
        begin : g_inner
            assign right_entry = entries[i+1];
        end

        rsse_cell #(
            .IDX (i),
            .CW  (CW)
        ) u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .count       (count),
            .position    (position),
            .left_entry  (left_entry),
            .left_after  (left_after),
            .right_entry (right_entry),
            .entry       (entries[i]),
            .flags       (flags[i])
        );
    end

    // At most one cell can be addressed, so an OR across the row is the read mux.
    always_comb
    begin
        found    = 1'b0;
        rd_found = 1'b0;
        rd_entry = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            found    = found | flags[i].eq;
            rd_found = rd_found | flags[i].rd_hit;
            rd_entry = rd_entry | (flags[i].rd_hit ? entries[i] : entry_t'('0));
        end
    end

endmodule

// ----- rtl/rank_sorted_set_engine_unit.sv -----
// The result of each accepted word is written straight to the output register.
// Throughput: one word per cycle unless stalled; cells check the broadcast rank
// and shift in the same cycle, and the output register frees as it is taken.
// Reset: rst_n clears the entry count and the output valid; the cell contents
// are left as they are and are never read before they are written.
// Top level of the rank-sorted set engine.
module rank_sorted_set_engine_unit #(
    parameter int CAPACITY = 256
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            opcode,
    input  logic [7:0]            element,
    input  logic [7:0]            element_rank,
    input  logic [7:0]            position,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [8:0]            entry_count,
    output logic [7:0]            read_element,
    output logic [7:0]            read_rank
);
    import rsse_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    status_t       status_reg;
    status_t       status_next;
    logic [8:0]    entry_count_reg;
    entry_t        read_reg;
    entry_t        read_next;

    logic       accept;
    logic       full;
    logic       found;
    logic       rd_found;
    entry_t     rd_entry;
    opcode_t    op;
    cell_cmd_t  cmd;

    assign op       = opcode_t'(opcode);
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign full     = count_reg == CW'(CAPACITY);

    always_comb
    begin
        cmd.ins_en            = accept && (op == OP_INSERT) && !full;
        cmd.rem_en            = accept && (op == OP_REMOVE) && found;
        cmd.rank              = element_rank;
        cmd.new_entry.rank    = element_rank;
        cmd.new_entry.element = element;
    end

    rsse_chain #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_chain (
        .clk      (clk),
        .cmd      (cmd),
        .count    (count_reg),
        .position (position),
        .found    (found),
        .rd_found (rd_found),
        .rd_entry (rd_entry)
    );

    always_comb
    begin
        count_next  = count_reg;
        status_next = ST_OK;
        read_next   = '0;
        unique case (op)
            OP_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            OP_REMOVE:
            begin
                if (found)
                begin
                    count_next = count_reg - CW'(1);
                end
                else
                begin
                    status_next = ST_ABSENT;
                end
            end
            OP_CLEAR:
            begin
                count_next = '0;
            end
            OP_READ:
            begin
                if (rd_found)
                begin
                    read_next = rd_entry;
                end
                else
                begin
                    status_next = ST_RANGE;
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            entry_count_reg <= 9'(count_next);
            read_reg        <= read_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign entry_count  = entry_count_reg;
    assign read_element = read_reg.element;
    assign read_rank    = read_reg.rank;

endmodule

// ----- rtl/rsse_checker.sv -----
// Port-level assertions for the rank-sorted set engine and their bind.
module rsse_checker #(
    parameter int CAPACITY = 256
) (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] opcode,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] status,
    input logic [8:0] entry_count,
    input logic [7:0] read_element,
    input logic [7:0] read_rank
);
    import rsse_pkg::*;

    // A stalled result word holds its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(entry_count) && $stable(read_element) && $stable(read_rank))
        else $error("result word changed while stalled");

    // A clear word yields an empty set with good status on the next cycle.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (opcode == OP_CLEAR)
            |=> out_valid && (status == ST_OK) && (entry_count == 9'd0))
        else $error("clear did not report an empty set");

    // A full status only comes back when the set holds its capacity.
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> entry_count == 9'(CAPACITY))
        else $error("full status with room left");

    // Read fields are zero on any word with a failed status.
    a_read_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (read_element == 8'd0) && (read_rank == 8'd0))
        else $error("read fields set on a failed word");

endmodule

bind rank_sorted_set_engine_unit rsse_checker #(.CAPACITY(CAPACITY)) u_rsse_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .opcode       (opcode),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .entry_count  (entry_count),
    .read_element (read_element),
    .read_rank    (read_rank)
);

// ----- verif/rank_sorted_set_engine_unit_tb.sv -----
// Self-checking testbench for the rank-sorted set engine top level.
`timescale 1ns / 100ps

module rank_sorted_set_engine_unit_tb;
    import rsse_pkg::*;

    localparam int CAPACITY = 256;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 5;

    typedef struct {
        opcode_t    op;
        logic [7:0] elem;
        logic [7:0] rank;
        logic [7:0] pos;
    } set_cmd_t;

    typedef struct {
        status_t    st;
        logic [8:0] cnt;
        logic [7:0] elem;
        logic [7:0] rank;
    } set_reply_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] opcode;
    logic [7:0] element;
    logic [7:0] element_rank;
    logic [7:0] position;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] status;
    logic [8:0] entry_count;
    logic [7:0] read_element;
    logic [7:0] read_rank;

    set_cmd_t    pending_cmds[$];
    set_reply_t  expected_replies[$];
    entry_t      shadow_entries[CAPACITY];
    int unsigned shadow_count;

    int unsigned total_cmds;
    int unsigned words_accepted;
    int unsigned replies_seen;
    int unsigned stall_cycles;
    int unsigned hold_left;
    int unsigned next_hold_at;
    bit          word_sent;
    bit          saw_failure;
    bit          run_over;
    logic        gap_free;
    set_cmd_t    next_cmd;
    set_cmd_t    taken_cmd;
    set_reply_t  want;

    rank_sorted_set_engine_unit #(
        .CAPACITY(CAPACITY)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .opcode(opcode),
        .element(element),
        .element_rank(element_rank),
        .position(position),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .status(status),
        .entry_count(entry_count),
        .read_element(read_element),
        .read_rank(read_rank)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Both sides run without gaps for a stretch in the middle of the run.
    assign gap_free = (replies_seen >= 700) && (replies_seen < 1000);

    // Applies one word to the shadow set and returns the result it must produce.
    function automatic set_reply_t sorted_set_outcome(set_cmd_t c);
        set_reply_t  r;
        int unsigned slot;
        int unsigned k;
        r.st = ST_OK;
        r.elem = 8'd0;
        r.rank = 8'd0;
        slot = 0;
        case (c.op)
            OP_INSERT:
            begin
                if (shadow_count >= CAPACITY)
                    r.st = ST_FULL;
                else
                begin
                    while (slot < shadow_count && shadow_entries[slot].rank <= c.rank)
                        slot++;
                    for (k = shadow_count; k > slot; k--)
                        shadow_entries[k] = shadow_entries[k - 1];
                    shadow_entries[slot].rank = c.rank;
                    shadow_entries[slot].element = c.elem;
                    shadow_count++;
                end
            end
            OP_REMOVE:
            begin
                while (slot < shadow_count && shadow_entries[slot].rank != c.rank)
                    slot++;
                if (slot >= shadow_count)
                    r.st = ST_ABSENT;
                else
                begin
                    for (k = slot; k + 1 < shadow_count; k++)
                        shadow_entries[k] = shadow_entries[k + 1];
                    shadow_count--;
                end
            end
            OP_CLEAR:
                shadow_count = 0;
            default:
            begin
                if (c.pos < shadow_count)
                begin
                    r.elem = shadow_entries[c.pos].element;
                    r.rank = shadow_entries[c.pos].rank;
                end
                else
                    r.st = ST_RANGE;
            end
        endcase
        r.cnt = shadow_count[8:0];
        return r;
    endfunction

    task automatic add_word(opcode_t op, logic [7:0] elem, logic [7:0] rank, logic [7:0] pos);
        set_cmd_t c;
        c.op = op;
        c.elem = elem;
        c.rank = rank;
        c.pos = pos;
        pending_cmds.push_back(c);
    endtask

    // Fields an operation ignores are random as well.
    task automatic add_random_words(int n, int ins_pct, int rem_pct, int clr_pct,
                                    int rank_max, int pos_max);
        int      pick;
        opcode_t op;
        repeat (n)
        begin
            pick = $urandom_range(99);
            if (pick < ins_pct)
                op = OP_INSERT;
            else if (pick < ins_pct + rem_pct)
                op = OP_REMOVE;
            else if (pick < ins_pct + rem_pct + clr_pct)
                op = OP_CLEAR;
            else
                op = OP_READ;
            add_word(op, 8'($urandom_range(255)), 8'($urandom_range(rank_max)),
                     8'($urandom_range(pos_max)));
        end
    endtask

    // Driver: a new word goes out only once the previous one was taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || word_sent)
            begin
                if (pending_cmds.size() > 0 && (gap_free || $urandom_range(99) >= 6))
                begin
                    next_cmd = pending_cmds.pop_front();
                    in_valid <= 1'b1;
                    opcode <= next_cmd.op;
                    element <= next_cmd.elem;
                    element_rank <= next_cmd.rank;
                    position <= next_cmd.pos;
                end
                else
                    in_valid <= 1'b0;
            end
            word_sent = 1'b0;
        end
    end

    // Receiver: random stalls, plus long hold-offs that back the block up.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left == 0 && replies_seen >= next_hold_at)
            begin
                hold_left = HOLD_CYCLES;
                next_hold_at = next_hold_at + 600;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= gap_free || ($urandom_range(99) >= 6);
        end
    end

    // Monitor: checks each result word, then predicts the word just accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                replies_seen++;
                if (expected_replies.size() == 0)
                begin
                    $error("unexpected result word: status %0d, entry_count %0d",
                           status, entry_count);
                    saw_failure = 1'b1;
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, status);
                        saw_failure = 1'b1;
                    end
                    if (entry_count !== want.cnt)
                    begin
                        $error("entry_count: expected %0d, got %0d", want.cnt, entry_count);
                        saw_failure = 1'b1;
                    end
                    if (read_element !== want.elem)
                    begin
                        $error("read_element: expected %0d, got %0d", want.elem, read_element);
                        saw_failure = 1'b1;
                    end
                    if (read_rank !== want.rank)
                    begin
                        $error("read_rank: expected %0d, got %0d", want.rank, read_rank);
                        saw_failure = 1'b1;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                taken_cmd.op = opcode_t'(opcode);
                taken_cmd.elem = element;
                taken_cmd.rank = element_rank;
                taken_cmd.pos = position;
                expected_replies.push_back(sorted_set_outcome(taken_cmd));
                words_accepted++;
                word_sent = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && !run_over)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                stall_cycles = 0;
            else
            begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT)
                begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        opcode = OP_READ;
        element = 8'd0;
        element_rank = 8'd0;
        position = 8'd0;
        shadow_count = 0;
        words_accepted = 0;
        replies_seen = 0;
        stall_cycles = 0;
        hold_left = 0;
        next_hold_at = 500;
        word_sent = 1'b0;
        saw_failure = 1'b0;
        run_over = 1'b0;

        // Empty set, field extremes, equal ranks, remove by rank alone, clear.
        add_word(OP_READ,   8'h00, 8'h00, 8'h00);
        add_word(OP_REMOVE, 8'hFF, 8'h00, 8'hFF);
        add_word(OP_INSERT, 8'hFF, 8'h80, 8'h00);
        add_word(OP_INSERT, 8'h00, 8'h00, 8'hFF);
        add_word(OP_INSERT, 8'h55, 8'hFF, 8'h00);
        add_word(OP_INSERT, 8'hAA, 8'h80, 8'h00);
        add_word(OP_READ,   8'h00, 8'h00, 8'h00);
        add_word(OP_READ,   8'h00, 8'h00, 8'h01);
        add_word(OP_READ,   8'h00, 8'h00, 8'h02);
        add_word(OP_READ,   8'h00, 8'h00, 8'h03);
        add_word(OP_READ,   8'h00, 8'h00, 8'h04);
        add_word(OP_READ,   8'h00, 8'h00, 8'hFF);
        add_word(OP_REMOVE, 8'h12, 8'h80, 8'h00);
        add_word(OP_READ,   8'h00, 8'h00, 8'h01);
        add_word(OP_REMOVE, 8'h00, 8'h7F, 8'h00);
        add_word(OP_REMOVE, 8'h00, 8'hFF, 8'h00);
        add_word(OP_READ,   8'hFF, 8'hFF, 8'h02);
        add_word(OP_CLEAR,  8'hFF, 8'hFF, 8'hFF);
        add_word(OP_READ,   8'h00, 8'h00, 8'h00);
        add_word(OP_INSERT, 8'h3C, 8'h01, 8'h00);
        add_word(OP_READ,   8'h00, 8'h00, 8'h00);
        add_word(OP_CLEAR,  8'h00, 8'h00, 8'h00);

        // Fill past capacity, drain with lookups, churn a few crowded ranks, then mix widely.
        add_random_words(350, 85, 5, 0, 255, 255);
        add_random_words(300, 15, 50, 0, 255, 255);
        add_random_words(400, 40, 35, 3, 7, 15);
        add_random_words(330, 40, 25, 5, 255, 255);
        total_cmds = pending_cmds.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
            @(negedge clk);
        while (words_accepted != total_cmds || expected_replies.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        run_over = 1'b1;

        if (!saw_failure)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- rank_sorted_set_engine_unit.f -----
rtl/rsse_pkg.sv
rtl/rsse_cell.sv
rtl/rsse_chain.sv
rtl/rank_sorted_set_engine_unit.sv
rtl/rsse_checker.sv
verif/rank_sorted_set_engine_unit_tb.sv
